[sv/cpk_pkg.sv]
// ----------------------------------------------------------------------------
// cpk_pkg - categorical product kernel shared definitions
// Widths, the microcode word layout, the control store and the status
// group that the datapath returns to the sequencer.
// ----------------------------------------------------------------------------
package cpk_pkg;

	// Field widths of the channel payloads
	localparam int CODE_W = 8;
	localparam int BW_W   = 17;

	// Arithmetic configuration
	localparam int CODE_BITS = 8;
	localparam int FRAC_BITS = 16;
	localparam int Q_BITS    = FRAC_BITS + 1;
	localparam int P_BITS    = 2 * Q_BITS;

	localparam logic [Q_BITS-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

	// Sequencer step addresses
	localparam int STEP_BITS = 3;
	typedef logic [STEP_BITS-1:0] step_t;

	localparam step_t ST_ACCEPT  = 3'd0;
	localparam step_t ST_POW_MUL = 3'd1;
	localparam step_t ST_POW_SQR = 3'd2;
	localparam step_t ST_FOLD    = 3'd3;
	localparam step_t ST_EMIT    = 3'd4;

	// Multiplier operand selection
	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_ACC,
		MUL_SQR,
		MUL_FOLD
	} mul_sel_t;

	// Conditions that keep the step counter where it is
	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_NO_ITEM,
		HOLD_OUT_BUSY
	} hold_t;

	// Jump conditions; the fall-through is the next step
	typedef enum logic [2:0] {
		JMP_NEVER,
		JMP_ALWAYS,
		JMP_DIRECT,
		JMP_DIST_MORE,
		JMP_NOT_LAST
	} jump_t;

	// One control word
	typedef struct packed {
		logic     load;
		logic     emit;
		mul_sel_t mul_sel;
		hold_t    hold;
		jump_t    jump;
		step_t    target;
	} uword_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic item_valid;
		logic direct;
		logic dist_more;
		logic last;
		logic out_busy;
	} dp_status_t;

	// Control store
	function automatic uword_t ucode_rom(input step_t step);
		uword_t w;
		w = '{load: 1'b0, emit: 1'b0, mul_sel: MUL_NONE, hold: HOLD_NONE,
			jump: JMP_ALWAYS, target: ST_ACCEPT};
		unique case (step)
			// take a beat; a direct factor skips the power loop
			ST_ACCEPT: begin
				w.load   = 1'b1;
				w.hold   = HOLD_NO_ITEM;
				w.jump   = JMP_DIRECT;
				w.target = ST_FOLD;
			end
			// acc *= base when the current distance bit is set
			ST_POW_MUL: begin
				w.mul_sel = MUL_ACC;
				w.jump    = JMP_NEVER;
			end
			// base *= base, loop while distance bits remain
			ST_POW_SQR: begin
				w.mul_sel = MUL_SQR;
				w.jump    = JMP_DIST_MORE;
				w.target  = ST_POW_MUL;
			end
			// fold factor into the row product
			ST_FOLD: begin
				w.mul_sel = MUL_FOLD;
				w.jump    = JMP_NOT_LAST;
				w.target  = ST_ACCEPT;
			end
			// hand the row result to the output register
			ST_EMIT: begin
				w.emit   = 1'b1;
				w.hold   = HOLD_OUT_BUSY;
				w.jump   = JMP_ALWAYS;
				w.target = ST_ACCEPT;
			end
			default: begin
				w.jump   = JMP_ALWAYS;
				w.target = ST_ACCEPT;
			end
		endcase
		return w;
	endfunction

endpackage

[sv/cpk_item_if.sv]
// ----------------------------------------------------------------------------
// cpk_item_if - input channel
// One beat carries one variable of a sample row.
// ----------------------------------------------------------------------------
interface cpk_item_if;
	logic                        valid;
	logic                        ready;
	logic [cpk_pkg::CODE_W-1:0]  sample_code;
	logic                        sample_missing;
	logic [cpk_pkg::CODE_W-1:0]  reference_code;
	logic                        reference_missing;
	logic [cpk_pkg::BW_W-1:0]    bandwidth;
	logic                        ordered_flag;
	logic                        last_of_row;

	modport source (
		output valid, sample_code, sample_missing, reference_code,
			reference_missing, bandwidth, ordered_flag, last_of_row,
		input  ready
	);

	modport sink (
		input  valid, sample_code, sample_missing, reference_code,
			reference_missing, bandwidth, ordered_flag, last_of_row,
		output ready
	);
endinterface

[sv/cpk_result_if.sv]
// ----------------------------------------------------------------------------
// cpk_result_if - output channel
// One beat carries the kernel product of one row.
// ----------------------------------------------------------------------------
interface cpk_result_if;
	logic                       valid;
	logic                       ready;
	logic [cpk_pkg::Q_BITS-1:0] kernel_product;
	logic                       undefined_result;

	modport source (
		output valid, kernel_product, undefined_result,
		input  ready
	);

	modport sink (
		input  valid, kernel_product, undefined_result,
		output ready
	);
endinterface

[sv/cpk_useq.sv]
// ----------------------------------------------------------------------------
// cpk_useq - microcode sequencer
// Step counter over the control store, with hold and conditional jumps
// driven by the datapath status.
// ----------------------------------------------------------------------------
module cpk_useq (
	input  logic                clk,
	input  logic                arst_n,
	input  cpk_pkg::dp_status_t status,
	output cpk_pkg::uword_t     ctrl,
	output logic                fire
);

	cpk_pkg::step_t step_q;
	cpk_pkg::step_t step_d;
	logic           hold;
	logic           take;

	// current control word
	assign ctrl = cpk_pkg::ucode_rom(step_q);

	// hold and jump decode
	always_comb begin
		unique case (ctrl.hold)
			cpk_pkg::HOLD_NO_ITEM:  hold = !status.item_valid;
			cpk_pkg::HOLD_OUT_BUSY: hold = status.out_busy;
			default:                hold = 1'b0;
		endcase

		unique case (ctrl.jump)
			cpk_pkg::JMP_ALWAYS:    take = 1'b1;
			cpk_pkg::JMP_DIRECT:    take = status.direct;
			cpk_pkg::JMP_DIST_MORE: take = status.dist_more;
			cpk_pkg::JMP_NOT_LAST:  take = !status.last;
			default:                take = 1'b0;
		endcase

		fire = !hold;
		if (hold) begin
			step_d = step_q;
		end else if (take) begin
			step_d = ctrl.target;
		end else begin
			step_d = step_q + cpk_pkg::step_t'(1);
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= cpk_pkg::ST_ACCEPT;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

[sv/cpk_dp.sv]
// ----------------------------------------------------------------------------
// cpk_dp - kernel datapath
// Factor decode, one shared Q1.16 multiplier, power registers, row
// product and the output register.
// ----------------------------------------------------------------------------
module cpk_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  cpk_pkg::uword_t     ctrl,
	input  logic                fire,
	output cpk_pkg::dp_status_t status,
	cpk_item_if.sink            item,
	cpk_result_if.source        result
);

	logic [cpk_pkg::CODE_BITS-1:0] s_code;
	logic [cpk_pkg::CODE_BITS-1:0] r_code;
	logic [cpk_pkg::CODE_BITS-1:0] code_gap;
	logic [cpk_pkg::Q_BITS-1:0]    lambda_sat;
	logic [cpk_pkg::Q_BITS-1:0]    direct_factor;
	logic                          any_miss;
	logic                          match;
	logic                          direct;

	logic [cpk_pkg::Q_BITS-1:0]    mul_a;
	logic [cpk_pkg::Q_BITS-1:0]    mul_b;
	logic [cpk_pkg::P_BITS-1:0]    mul_full;
	logic [cpk_pkg::Q_BITS-1:0]    mul_q;

	logic [cpk_pkg::CODE_BITS-1:0] dist_q;
	logic [cpk_pkg::Q_BITS-1:0]    acc_q;
	logic [cpk_pkg::Q_BITS-1:0]    base_q;
	logic                          last_q;
	logic [cpk_pkg::Q_BITS-1:0]    prod_q;
	logic                          undef_q;
	logic                          out_valid_q;
	logic [cpk_pkg::Q_BITS-1:0]    out_prod_q;
	logic                          out_undef_q;
	logic                          out_busy;

	// factor decode of the incoming beat
	always_comb begin
		s_code   = item.sample_code[cpk_pkg::CODE_BITS-1:0];
		r_code   = item.reference_code[cpk_pkg::CODE_BITS-1:0];
		any_miss = item.sample_missing || item.reference_missing;
		match    = !any_miss && (s_code == r_code);
		direct   = match || !item.ordered_flag || any_miss;
		code_gap = (s_code > r_code) ? (s_code - r_code) : (r_code - s_code);
		if (item.bandwidth > cpk_pkg::BW_W'(cpk_pkg::ONE_Q)) begin
			lambda_sat = cpk_pkg::ONE_Q;
		end else begin
			lambda_sat = cpk_pkg::Q_BITS'(item.bandwidth);
		end
		// ordered with a missing value is taken as one
		if (match || (item.ordered_flag && any_miss)) begin
			direct_factor = cpk_pkg::ONE_Q;
		end else begin
			direct_factor = lambda_sat;
		end
	end

	// shared multiplier, truncated back to Q1.16
	always_comb begin
		case (ctrl.mul_sel)
			cpk_pkg::MUL_ACC: begin
				mul_a = acc_q;
				mul_b = base_q;
			end
			cpk_pkg::MUL_SQR: begin
				mul_a = base_q;
				mul_b = base_q;
			end
			cpk_pkg::MUL_FOLD: begin
				mul_a = prod_q;
				mul_b = acc_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_full = mul_a * mul_b;
		mul_q    = mul_full[cpk_pkg::FRAC_BITS +: cpk_pkg::Q_BITS];
	end

	// power loop registers
	always_ff @(posedge clk) begin
		if (fire && ctrl.load) begin
			last_q <= item.last_of_row;
			dist_q <= code_gap;
			base_q <= lambda_sat;
			acc_q  <= direct ? direct_factor : cpk_pkg::ONE_Q;
		end
		if (fire && (ctrl.mul_sel == cpk_pkg::MUL_ACC) && dist_q[0]) begin
			acc_q <= mul_q;
		end
		if (fire && (ctrl.mul_sel == cpk_pkg::MUL_SQR)) begin
			base_q <= mul_q;
			dist_q <= dist_q >> 1;
		end
	end

	// row product and sticky undefined flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q  <= cpk_pkg::ONE_Q;
			undef_q <= 1'b0;
		end else if (fire) begin
			if (ctrl.load && item.ordered_flag && any_miss &&
				(lambda_sat != cpk_pkg::ONE_Q)) begin
				undef_q <= 1'b1;
			end
			if (ctrl.mul_sel == cpk_pkg::MUL_FOLD) begin
				prod_q <= mul_q;
			end
			if (ctrl.emit) begin
				prod_q  <= cpk_pkg::ONE_Q;
				undef_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctrl.emit) begin
			out_prod_q  <= undef_q ? '0 : prod_q;
			out_undef_q <= undef_q;
		end
	end

	assign out_busy = out_valid_q && !result.ready;

	assign item.ready              = ctrl.load;
	assign result.valid            = out_valid_q;
	assign result.kernel_product   = out_prod_q;
	assign result.undefined_result = out_undef_q;

	assign status.item_valid = item.valid;
	assign status.direct     = direct;
	assign status.dist_more  = (dist_q >> 1) != '0;
	assign status.last       = last_q;
	assign status.out_busy   = out_busy;

endmodule

[sv/categorical_product_kernel_unit.sv]
// ----------------------------------------------------------------------------
// categorical_product_kernel_unit - categorical product kernel, top level
// Streams row variables, forms each kernel factor and multiplies it into
// a Q1.16 row product, emitting one result beat per row.
//
//   channel  dir  beat                       handshake
//   item     in   one variable of a row      valid/ready
//   result   out  row product + undef flag   valid/ready
//
// Steps: a matching, unordered or missing variable runs accept, then fold;
// an ordered mismatch runs the multiply and square steps in a loop over the
// distance bits up to the top set bit, at most CODE_BITS of them. The single
// shared multiplier is why these steps run in turn. The last variable of a row
// adds an emit step. Reset clears the row product to one and the flag to zero.
// The output register lets the next row start while a result beat waits;
// the emit step stalls only if the previous result is still untaken.
// ----------------------------------------------------------------------------
module categorical_product_kernel_unit (
	input  logic          clk,
	input  logic          arst_n,
	cpk_item_if.sink      item,
	cpk_result_if.source  result
);

	cpk_pkg::uword_t     ctrl;
	cpk_pkg::dp_status_t status;
	logic                fire;

	// sequencer
	cpk_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl),
		.fire   (fire)
	);

	// datapath
	cpk_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.fire   (fire),
		.status (status),
		.item   (item),
		.result (result)
	);

endmodule

[sim/tb_categorical_product_kernel_unit.sv]
// ----------------------------------------------------------------------------
// tb_categorical_product_kernel_unit - row kernel product testbench
// Streams row variables into the kernel unit and checks every row result.
// A behavioural model of the factor and row product arithmetic predicts each
// result. Directed beats cover field extremes and every kernel case. Random
// rows then run under four idling modes on the two channels.
// ----------------------------------------------------------------------------
module tb_categorical_product_kernel_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 40;

	// One variable of a sample row, as carried by an item beat
	typedef struct {
		logic [cpk_pkg::CODE_W-1:0] sample_code;
		logic                       sample_missing;
		logic [cpk_pkg::CODE_W-1:0] reference_code;
		logic                       reference_missing;
		logic [cpk_pkg::BW_W-1:0]   bandwidth;
		logic                       ordered_flag;
		logic                       last_of_row;
	} row_var_t;

	// One row result, as carried by a result beat
	typedef struct {
		logic [cpk_pkg::Q_BITS-1:0] kernel_product;
		logic                       undefined_result;
	} row_result_t;

	logic clk;
	logic arst_n;

	cpk_item_if   item_ch ();
	cpk_result_if result_ch ();

	categorical_product_kernel_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Model state of the row being accumulated
	logic [cpk_pkg::Q_BITS-1:0] model_row_product = cpk_pkg::ONE_Q;
	logic                       model_undefined   = 1'b0;
	row_result_t                expected_rows[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int error_count    = 0;
	int vars_sent      = 0;
	int rows_checked   = 0;
	int undefined_rows = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog
	initial begin
		#10ms;
		$error("timeout: %0d row results still pending", expected_rows.size());
		$display("Some tests failed");
		$finish;
	end

	// Truncating Q1.16 multiply
	function automatic logic [cpk_pkg::Q_BITS-1:0] q_mul(
			input logic [cpk_pkg::Q_BITS-1:0] a,
			input logic [cpk_pkg::Q_BITS-1:0] b);
		logic [cpk_pkg::P_BITS-1:0] prod;
		prod = {{cpk_pkg::Q_BITS{1'b0}}, a} * {{cpk_pkg::Q_BITS{1'b0}}, b};
		return prod[cpk_pkg::FRAC_BITS +: cpk_pkg::Q_BITS];
	endfunction

	// lambda^gap, LSB-first square-and-multiply, truncating each step
	function automatic logic [cpk_pkg::Q_BITS-1:0] lambda_power(
			input logic [cpk_pkg::Q_BITS-1:0] lambda,
			input logic [cpk_pkg::CODE_W-1:0] gap);
		logic [cpk_pkg::Q_BITS-1:0] acc;
		logic [cpk_pkg::Q_BITS-1:0] base;
		acc  = cpk_pkg::ONE_Q;
		base = lambda;
		for (int i = 0; i < cpk_pkg::CODE_BITS; i++) begin
			if (gap[i])
				acc = q_mul(acc, base);
			base = q_mul(base, base);
		end
		return acc;
	endfunction

	// Fold one accepted variable into the model row; queue the row at its end
	task automatic fold_variable(input row_var_t v);
		logic [cpk_pkg::Q_BITS-1:0] lambda;
		logic [cpk_pkg::Q_BITS-1:0] factor;
		logic [cpk_pkg::CODE_W-1:0] code_gap;
		logic                       any_missing;
		row_result_t                row;
		lambda      = (v.bandwidth > cpk_pkg::ONE_Q) ? cpk_pkg::ONE_Q : v.bandwidth;
		any_missing = v.sample_missing || v.reference_missing;
		code_gap    = (v.sample_code > v.reference_code) ?
			v.sample_code - v.reference_code : v.reference_code - v.sample_code;
		if (!any_missing && v.sample_code == v.reference_code) begin
			factor = cpk_pkg::ONE_Q;
		end else if (!v.ordered_flag) begin
			factor = lambda;
		end else if (any_missing) begin
			// missing ordered value: undefined unless lambda is exactly one
			if (lambda != cpk_pkg::ONE_Q)
				model_undefined = 1'b1;
			factor = cpk_pkg::ONE_Q;
		end else begin
			factor = lambda_power(lambda, code_gap);
		end
		model_row_product = q_mul(model_row_product, factor);
		if (v.last_of_row) begin
			row.kernel_product   = model_undefined ? '0 : model_row_product;
			row.undefined_result = model_undefined;
			expected_rows.push_back(row);
			model_row_product = cpk_pkg::ONE_Q;
			model_undefined   = 1'b0;
		end
	endtask

	// Drive one variable beat; valid stays high afterwards unless a gap follows
	task automatic send_variable(input row_var_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid             <= 1'b1;
		item_ch.sample_code       <= v.sample_code;
		item_ch.sample_missing    <= v.sample_missing;
		item_ch.reference_code    <= v.reference_code;
		item_ch.reference_missing <= v.reference_missing;
		item_ch.bandwidth         <= v.bandwidth;
		item_ch.ordered_flag      <= v.ordered_flag;
		item_ch.last_of_row       <= v.last_of_row;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		fold_variable(v);
		vars_sent++;
	endtask

	function automatic row_var_t make_var(input int s, input bit sm, input int r,
			input bit rm, input int bw, input bit ord, input bit last);
		row_var_t v;
		v.sample_code       = s[cpk_pkg::CODE_W-1:0];
		v.sample_missing    = sm;
		v.reference_code    = r[cpk_pkg::CODE_W-1:0];
		v.reference_missing = rm;
		v.bandwidth         = bw[cpk_pkg::BW_W-1:0];
		v.ordered_flag      = ord;
		v.last_of_row       = last;
		return v;
	endfunction

	// Random variable, biased towards matches, short distances and usable lambdas
	function automatic row_var_t random_var();
		row_var_t v;
		v.sample_code = cpk_pkg::CODE_W'($urandom_range(255));
		case ($urandom_range(9))
			0, 1, 2: v.reference_code = v.sample_code;
			3, 4, 5: v.reference_code = v.sample_code +
				cpk_pkg::CODE_W'($urandom_range(1, 7));
			default: v.reference_code = cpk_pkg::CODE_W'($urandom_range(255));
		endcase
		v.sample_missing    = ($urandom_range(15) == 0);
		v.reference_missing = ($urandom_range(15) == 0);
		case ($urandom_range(9))
			0:          v.bandwidth = '0;
			1:          v.bandwidth = cpk_pkg::ONE_Q;
			2:          v.bandwidth = cpk_pkg::BW_W'($urandom_range(cpk_pkg::ONE_Q + 1,
				(1 << cpk_pkg::BW_W) - 1));
			3, 4, 5:    v.bandwidth = cpk_pkg::BW_W'($urandom_range(cpk_pkg::ONE_Q - 4096,
				cpk_pkg::ONE_Q));
			default:    v.bandwidth = cpk_pkg::BW_W'($urandom_range(0, cpk_pkg::ONE_Q));
		endcase
		v.ordered_flag = 1'($urandom_range(1));
		v.last_of_row  = 1'b0;
		return v;
	endfunction

	// Random rows of 1 to 6 variables, occasionally up to 12
	task automatic send_random_rows(input int n_vars);
		int left;
		int row_len;
		row_var_t v;
		left = n_vars;
		while (left > 0) begin
			row_len = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
			if (row_len > left)
				row_len = left;
			for (int i = 0; i < row_len; i++) begin
				v = random_var();
				v.last_of_row = (i == row_len - 1);
				send_variable(v);
			end
			left -= row_len;
		end
	endtask

	// Hold the sender off until every pending row result has come back
	task automatic wait_rows_drained();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_field_extremes();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_variable(make_var(0, 0, 0, 0, 0, 0, 1));
		send_variable(make_var(255, 1, 255, 1, 131071, 1, 1));
		send_variable(make_var(0, 0, 255, 0, cpk_pkg::ONE_Q + 1, 1, 1));
		send_variable(make_var(255, 0, 0, 0, cpk_pkg::ONE_Q - 1, 1, 1));
		send_variable(make_var(0, 0, 255, 0, 0, 0, 1));
		wait_rows_drained();
	endtask

	task automatic test_kernel_cases();
		// unordered and ordered mismatches and a match folded into one row
		send_variable(make_var(3, 0, 7, 0, 32768, 0, 0));
		send_variable(make_var(10, 0, 11, 0, 52000, 1, 0));
		send_variable(make_var(20, 0, 15, 0, 60000, 1, 0));
		send_variable(make_var(42, 0, 42, 0, 1234, 1, 1));
		// top distance bit only; lambda above one saturates
		send_variable(make_var(128, 0, 0, 0, 65000, 1, 1));
		send_variable(make_var(1, 0, 2, 0, 100000, 0, 1));
		wait_rows_drained();
	endtask

	task automatic test_missing_values();
		// unordered missing never matches
		send_variable(make_var(9, 1, 9, 0, 40000, 0, 1));
		send_variable(make_var(9, 0, 9, 1, 40000, 0, 0));
		send_variable(make_var(5, 1, 5, 0, cpk_pkg::ONE_Q, 1, 1));
		// undefined row, then the flag must clear for the next row
		send_variable(make_var(5, 0, 6, 1, 50000, 1, 0));
		send_variable(make_var(1, 0, 200, 0, 30000, 1, 0));
		send_variable(make_var(3, 0, 3, 0, 0, 0, 1));
		send_variable(make_var(3, 0, 4, 0, 45000, 0, 1));
		send_variable(make_var(0, 1, 0, 1, 131071, 1, 1));
		send_variable(make_var(7, 0, 8, 1, 0, 1, 1));
		wait_rows_drained();
	endtask

	task automatic test_back_to_back();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_random_rows(500);
		wait_rows_drained();
	endtask

	task automatic test_sender_gaps();
		send_idle_pct  = 51;
		recv_stall_pct = 0;
		send_random_rows(450);
		wait_rows_drained();
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct  = 0;
		recv_stall_pct = 51;
		send_random_rows(450);
		wait_rows_drained();
	endtask

	task automatic test_mixed_idling();
		send_idle_pct  = 32;
		recv_stall_pct = 32;
		send_random_rows(450);
		wait_rows_drained();
	endtask

	// Sender pauses mid-stream until the block has handed back every row
	task automatic test_idle_drain();
		send_idle_pct  = 0;
		recv_stall_pct = 32;
		for (int i = 0; i < 3; i++) begin
			send_random_rows(12);
			wait_rows_drained();
		end
	endtask

	// Result sink: random back-pressure and in-order comparison
	always @(posedge clk) begin : result_check
		row_result_t exp_row;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_rows.size() == 0) begin
				$error("result beat with no row pending: kernel_product %0d undefined_result %0b",
					result_ch.kernel_product, result_ch.undefined_result);
				error_count++;
			end else begin
				exp_row = expected_rows.pop_front();
				rows_checked++;
				if (exp_row.undefined_result)
					undefined_rows++;
				if (result_ch.kernel_product !== exp_row.kernel_product) begin
					$error("kernel_product: expected %0d, got %0d",
						exp_row.kernel_product, result_ch.kernel_product);
					error_count++;
				end
				if (result_ch.undefined_result !== exp_row.undefined_result) begin
					$error("undefined_result: expected %0b, got %0b",
						exp_row.undefined_result, result_ch.undefined_result);
					error_count++;
				end
			end
		end
		result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Test sequence
	initial begin
		arst_n                    = 1'b0;
		item_ch.valid             <= 1'b0;
		item_ch.sample_code       <= '0;
		item_ch.sample_missing    <= 1'b0;
		item_ch.reference_code    <= '0;
		item_ch.reference_missing <= 1'b0;
		item_ch.bandwidth         <= '0;
		item_ch.ordered_flag      <= 1'b0;
		item_ch.last_of_row       <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_kernel_cases();
		test_missing_values();
		test_back_to_back();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_idling();
		test_idle_drain();

		$display("Sent %0d row variables; checked %0d row results, %0d of them undefined,",
			vars_sent, rows_checked, undefined_rows);
		$display("under no idling, sender gaps, receiver stalls and both together.");
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
